FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/iems_pkg.sv
// Types, status codes and control-register masks for the I2C EEPROM sequencer.
package iems_pkg;

    // Request kinds and start operations
    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] OP_WRITE_BYTE  = 2'd0;
    localparam logic [1:0] OP_WRITE_BLOCK = 2'd1;
    localparam logic [1:0] OP_READ_BYTE   = 2'd2;
    localparam logic [1:0] OP_READ_BLOCK  = 2'd3;

    // Controller status codes
    localparam logic [7:0] ST_START_SENT   = 8'h08;
    localparam logic [7:0] ST_RESTART_SENT = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK   = 8'h18;
    localparam logic [7:0] ST_ADDR_W_NACK  = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK   = 8'h28;
    localparam logic [7:0] ST_DATA_W_NACK  = 8'h30;
    localparam logic [7:0] ST_ARB_LOST     = 8'h38;
    localparam logic [7:0] ST_ADDR_R_ACK   = 8'h40;
    localparam logic [7:0] ST_ADDR_R_NACK  = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK   = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK  = 8'h58;

    // Control register bits
    localparam logic [7:0] CTL_AA  = 8'h04;
    localparam logic [7:0] CTL_SI  = 8'h08;
    localparam logic [7:0] CTL_STO = 8'h10;
    localparam logic [7:0] CTL_STA = 8'h20;
    localparam logic [7:0] CTL_EN  = 8'h40;

    localparam logic [7:0] RW_BIT  = 8'h01;

    // Outcomes and error codes
    localparam logic [1:0] OUTCOME_BUSY   = 2'd0;
    localparam logic [1:0] OUTCOME_DONE   = 2'd1;
    localparam logic [1:0] OUTCOME_FAILED = 2'd2;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_ADDR_W_NACK = 3'd1;
    localparam logic [2:0] ERR_DATA_NACK   = 3'd2;
    localparam logic [2:0] ERR_ARB_LOST    = 3'd3;
    localparam logic [2:0] ERR_ADDR_R_NACK = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [1:0]  op;
        logic [7:0]  device_address;
        logic [15:0] memory_address;
        logic [7:0]  byte_count;
        logic [7:0]  status_code;
        logic [7:0]  bus_rx_byte;
        logic [7:0]  tx_byte;
    } in_item_t;

    typedef struct packed {
        logic       dat_write;
        logic [7:0] dat_value;
        logic [7:0] set_mask;
        logic [7:0] clear_mask;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_taken;
        logic [1:0] finished;
        logic [2:0] error_code;
    } out_item_t;

    typedef struct packed {
        logic fill_repeat;
    } cfg_item_t;

endpackage

FILE: rtl/iems_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
interface iems_in_if;
    logic               valid;
    logic               ready;
    iems_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface iems_out_if;
    logic                valid;
    logic                ready;
    iems_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface iems_cfg_if;
    logic                valid;
    logic                ready;
    iems_pkg::cfg_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/iems_in_stage.sv
// Input register: holds one request until the step logic takes it.
module iems_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  iems_pkg::in_item_t in_item,
    output logic               in_ready,
    input  logic               advance,
    output logic               held_valid,
    output iems_pkg::in_item_t held_item
);

    logic               valid_reg;
    iems_pkg::in_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

FILE: rtl/iems_core.sv
// Transaction state and the per-request step logic.
module iems_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  iems_pkg::in_item_t  item,
    input  logic                fill_repeat,
    output iems_pkg::out_item_t result
);

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_READ_SUB,
        MODE_WRITE_SUB
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic        low_sent_reg, low_sent_next;
    logic [7:0]  slave_reg, slave_next;
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  left_reg, left_next;
    logic [1:0]  outcome_reg, outcome_next;
    logic [2:0]  error_reg, error_next;

    always_comb
    begin
        mode_next     = mode_reg;
        low_sent_next = low_sent_reg;
        slave_next    = slave_reg;
        offset_next   = offset_reg;
        left_next     = left_reg;
        outcome_next  = outcome_reg;
        error_next    = error_reg;
        result        = '0;

        if (item.kind == iems_pkg::KIND_START)
        begin
            if (item.op == iems_pkg::OP_READ_BLOCK && item.byte_count == 8'd0)
            begin
                outcome_next = iems_pkg::OUTCOME_FAILED;
                error_next   = iems_pkg::ERR_NONE;
            end
            else
            begin
                slave_next  = (item.op == iems_pkg::OP_READ_BYTE ||
                               item.op == iems_pkg::OP_READ_BLOCK)
                              ? item.device_address + 8'd1 : item.device_address;
                offset_next = item.memory_address;
                left_next   = (item.op == iems_pkg::OP_WRITE_BLOCK ||
                               item.op == iems_pkg::OP_READ_BLOCK) ? item.byte_count : 8'd1;
                case (item.op)
                    iems_pkg::OP_READ_BLOCK:  mode_next = MODE_READ_SUB;
                    iems_pkg::OP_WRITE_BLOCK: mode_next = MODE_WRITE_SUB;
                    default:                  mode_next = MODE_NONE;
                endcase
                outcome_next      = iems_pkg::OUTCOME_BUSY;
                result.clear_mask = iems_pkg::CTL_STA | iems_pkg::CTL_SI | iems_pkg::CTL_AA;
                result.set_mask   = iems_pkg::CTL_EN | iems_pkg::CTL_STA;
            end
        end
        else
        begin
            case (item.status_code)
                iems_pkg::ST_START_SENT:
                begin
                    result.dat_write  = 1'b1;
                    result.dat_value  = (mode_reg == MODE_READ_SUB)
                                        ? (slave_reg & ~iems_pkg::RW_BIT) : slave_reg;
                    result.clear_mask = iems_pkg::CTL_STA | iems_pkg::CTL_SI;
                end
                iems_pkg::ST_RESTART_SENT:
                begin
                    result.dat_write  = 1'b1;
                    result.dat_value  = slave_reg;
                    result.clear_mask = iems_pkg::CTL_STA | iems_pkg::CTL_SI;
                end
                iems_pkg::ST_ADDR_W_ACK, iems_pkg::ST_DATA_W_ACK:
                begin
                    if (mode_reg == MODE_NONE)
                    begin
                        result.clear_mask = iems_pkg::CTL_STA | iems_pkg::CTL_SI;
                        if (left_reg != 8'd0)
                        begin
                            result.dat_write = 1'b1;
                            result.dat_value = item.tx_byte;
                            result.tx_taken  = !fill_repeat;
                            left_next        = left_reg - 8'd1;
                        end
                        else
                        begin
                            result.set_mask = iems_pkg::CTL_STO;
                            outcome_next    = iems_pkg::OUTCOME_DONE;
                        end
                    end
                    else if (item.status_code == iems_pkg::ST_ADDR_W_ACK)
                    begin
                        // Address acked: send the high offset byte first
                        if (mode_reg == MODE_READ_SUB || mode_reg == MODE_WRITE_SUB)
                        begin
                            result.dat_write  = 1'b1;
                            result.dat_value  = offset_reg[15:8];
                            result.clear_mask = iems_pkg::CTL_STA | iems_pkg::CTL_SI;
                        end
                    end
                    else if (mode_reg == MODE_READ_SUB)
                    begin
                        if (!low_sent_reg)
                        begin
                            result.dat_write  = 1'b1;
                            result.dat_value  = offset_reg[7:0];
                            result.clear_mask = iems_pkg::CTL_STA | iems_pkg::CTL_SI;
                            low_sent_next     = 1'b1;
                        end
                        else
                        begin
                            // Offset sent: issue the repeated start
                            result.set_mask   = iems_pkg::CTL_STA;
                            result.clear_mask = iems_pkg::CTL_SI;
                            low_sent_next     = 1'b0;
                            mode_next         = MODE_NONE;
                        end
                    end
                    else if (mode_reg == MODE_WRITE_SUB)
                    begin
                        result.dat_write  = 1'b1;
                        result.dat_value  = offset_reg[7:0];
                        result.clear_mask = iems_pkg::CTL_STA | iems_pkg::CTL_SI;
                        mode_next         = MODE_NONE;
                    end
                end
                iems_pkg::ST_ADDR_W_NACK:
                begin
                    error_next        = iems_pkg::ERR_ADDR_W_NACK;
                    result.clear_mask = iems_pkg::CTL_STA | iems_pkg::CTL_SI;
                    outcome_next      = iems_pkg::OUTCOME_FAILED;
                end
                iems_pkg::ST_DATA_W_NACK:
                begin
                    error_next        = iems_pkg::ERR_DATA_NACK;
                    result.clear_mask = iems_pkg::CTL_STA | iems_pkg::CTL_SI;
                    outcome_next      = iems_pkg::OUTCOME_FAILED;
                end
                iems_pkg::ST_ARB_LOST:
                begin
                    error_next        = iems_pkg::ERR_ARB_LOST;
                    result.clear_mask = iems_pkg::CTL_STA | iems_pkg::CTL_SI;
                    outcome_next      = iems_pkg::OUTCOME_FAILED;
                end
                iems_pkg::ST_ADDR_R_NACK:
                begin
                    error_next        = iems_pkg::ERR_ADDR_R_NACK;
                    result.clear_mask = iems_pkg::CTL_STA | iems_pkg::CTL_SI;
                    outcome_next      = iems_pkg::OUTCOME_FAILED;
                end
                iems_pkg::ST_ADDR_R_ACK, iems_pkg::ST_DATA_R_ACK:
                begin
                    if (item.status_code == iems_pkg::ST_DATA_R_ACK)
                    begin
                        result.rx_valid = 1'b1;
                        result.rx_byte  = item.bus_rx_byte;
                        left_next       = left_reg - 8'd1;
                    end
                    // Drop the acknowledge ahead of the last byte
                    if (left_next == 8'd1)
                    begin
                        result.clear_mask = iems_pkg::CTL_STA | iems_pkg::CTL_SI |
                                            iems_pkg::CTL_AA;
                    end
                    else
                    begin
                        result.set_mask   = iems_pkg::CTL_AA;
                        result.clear_mask = iems_pkg::CTL_STA | iems_pkg::CTL_SI;
                    end
                end
                iems_pkg::ST_DATA_R_NACK:
                begin
                    result.rx_valid   = 1'b1;
                    result.rx_byte    = item.bus_rx_byte;
                    result.set_mask   = iems_pkg::CTL_STO;
                    result.clear_mask = iems_pkg::CTL_STA | iems_pkg::CTL_SI;
                    outcome_next      = iems_pkg::OUTCOME_DONE;
                end
                default:
                begin
                    result.clear_mask = iems_pkg::CTL_STA | iems_pkg::CTL_SI;
                end
            endcase
        end

        result.finished   = outcome_next;
        result.error_code = (outcome_next == iems_pkg::OUTCOME_FAILED)
                            ? error_next : iems_pkg::ERR_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_NONE;
            low_sent_reg <= 1'b0;
            slave_reg    <= 8'd0;
            offset_reg   <= 16'd0;
            left_reg     <= 8'd0;
            outcome_reg  <= iems_pkg::OUTCOME_BUSY;
            error_reg    <= iems_pkg::ERR_NONE;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            low_sent_reg <= low_sent_next;
            slave_reg    <= slave_next;
            offset_reg   <= offset_next;
            left_reg     <= left_next;
            outcome_reg  <= outcome_next;
            error_reg    <= error_next;
        end
    end

endmodule

FILE: rtl/iems_out_stage.sv
// Result register: holds one result until the consumer takes it.
module iems_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  iems_pkg::out_item_t load_item,
    output logic                can_load,
    output logic                out_valid,
    output iems_pkg::out_item_t out_item,
    input  logic                out_ready
);

    logic                valid_reg;
    iems_pkg::out_item_t item_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

endmodule

FILE: rtl/i2c_eeprom_master_sequencer.sv
// Top level of the I2C EEPROM master sequencer.
//
//   channel  role    payload       moves
//   item     sink    in_item_t     start or status request
//   result   source  out_item_t    controller actions and outcome
//   cfg      sink    cfg_item_t    fill_repeat register write
//
// One request per cycle sustained while results are taken; a result is offered once its
// request has passed the input register and the step logic into the result register.
// Transaction state updates in the same cycle the result register loads.
// Reset clears valid flags and transaction state, outcome reads busy; cfg is always ready.
// A stalled result holds the step logic; the input register takes a request only if empty.
module i2c_eeprom_master_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    iems_in_if.sink    item,
    iems_out_if.source result,
    iems_cfg_if.sink   cfg
);

    logic                held_valid;
    iems_pkg::in_item_t  held_item;
    iems_pkg::out_item_t step_result;
    logic                can_load;
    logic                advance;
    logic                fill_repeat_reg;

    assign advance   = held_valid && can_load;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_repeat_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            fill_repeat_reg <= cfg.payload.fill_repeat;
        end
    end

    iems_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (item.valid),
        .in_item    (item.payload),
        .in_ready   (item.ready),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    iems_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (held_item),
        .fill_repeat (fill_repeat_reg),
        .result      (step_result)
    );

    iems_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .load_item (step_result),
        .can_load  (can_load),
        .out_valid (result.valid),
        .out_item  (result.payload),
        .out_ready (result.ready)
    );

endmodule

FILE: rtl/iems_checker.sv
// Port-level checks on the sequencer results, bound to the top level.
`include "assert_macros.svh"

module iems_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input iems_pkg::out_item_t out_item
);

    `ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))
    `ASSERT_IMPLY(a_finished_code, clk, rst_n, out_valid, out_item.finished != 2'd3)
    `ASSERT_IMPLY(a_error_only_on_fail, clk, rst_n, out_valid && out_item.error_code != iems_pkg::ERR_NONE, out_item.finished == iems_pkg::OUTCOME_FAILED && out_item.error_code <= iems_pkg::ERR_ADDR_R_NACK)
    `ASSERT_IMPLY(a_quiet_payload, clk, rst_n, out_valid, (out_item.rx_valid || out_item.rx_byte == 8'd0) && (out_item.dat_write || out_item.dat_value == 8'd0))

endmodule

bind i2c_eeprom_master_sequencer iems_checker u_iems_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_item  (result.payload)
);
